@@ hw/rtl/pcl_pkg.sv @@
// ----------------------------------------------------------------------------
// pcl_pkg: shared types and constants of the positional character list
// Transaction payload types, operation and status codes, default capacity.
// ----------------------------------------------------------------------------
package pcl_pkg;

    localparam int PCL_CAPACITY = 32;
    localparam int POS_W        = 6;
    localparam int CHAR_W       = 8;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_GET    = 2'd2,
        KIND_PRINT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BADPOS = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [CHAR_W-1:0] value_out;
        logic              last;
    } rsp_t;

endpackage

@@ hw/rtl/pcl_ram.sv @@
// ----------------------------------------------------------------------------
// pcl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module pcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/pcl_seq.sv @@
// ----------------------------------------------------------------------------
// pcl_seq: operation sequencer of the positional character list
// Checks each request, then walks the element store one cell at a time to
// shift, fetch or stream elements through the single RAM port pair.
// ----------------------------------------------------------------------------
module pcl_seq #(
    parameter int CAPACITY = pcl_pkg::PCL_CAPACITY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  pcl_pkg::req_t               req,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pcl_pkg::rsp_t               res,
    output logic                        ram_we,
    output logic [$clog2(CAPACITY)-1:0] ram_waddr,
    output logic [pcl_pkg::CHAR_W-1:0]  ram_wdata,
    output logic                        ram_re,
    output logic [$clog2(CAPACITY)-1:0] ram_raddr,
    input  logic [pcl_pkg::CHAR_W-1:0]  ram_rdata
);

    import pcl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FETCH,
        S_FETCH_DATA,
        S_DEL_RD,
        S_DEL_WR,
        S_PRINT_RD,
        S_PRINT_EMIT,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [CHAR_W-1:0] val_reg, val_next;
    logic [AW-1:0]     tgt_reg, tgt_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    rsp_t              res_reg, res_next;

    logic [EW-1:0]     pos_e, cnt_e;
    logic [CW-1:0]     idx_m1, idx_p1;
    logic              print_last;

    assign pos_e      = EW'(req.position);
    assign cnt_e      = EW'(count_reg);
    assign idx_m1     = idx_reg - CW'(1);
    assign idx_p1     = idx_reg + CW'(1);
    assign print_last = (idx_p1 == count_reg);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        val_next   = val_reg;
        tgt_next   = tgt_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        res_next   = res_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        res        = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg[AW-1:0];
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    kind_next = req.kind;
                    val_next  = req.value;
                    tgt_next  = AW'(req.position - POS_W'(1));
                    res_next  = '{status: STATUS_OK, value_out: '0, last: 1'b1};
                    unique case (req.kind) inside
                        KIND_INSERT:
                        begin
                            if (req.position == '0 || pos_e > cnt_e + EW'(1))
                            begin
                                res_next.status = STATUS_BADPOS;
                                state_next      = S_EMIT;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                res_next.status = STATUS_FULL;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        KIND_DELETE, KIND_GET:
                        begin
                            if (req.position == '0 || pos_e > cnt_e)
                            begin
                                res_next.status = STATUS_BADPOS;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_FETCH;
                            end
                        end
                        KIND_PRINT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = STATUS_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_PRINT_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Move cells up one at a time, top first; drop the new byte in
            // once the walk reaches its slot.
            S_SHIFT_RD:
            begin
                if (idx_reg == CW'(tgt_reg))
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_m1[AW-1:0];
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_m1;
                state_next = S_SHIFT_RD;
            end

            S_FETCH:
            begin
                ram_re     = 1'b1;
                ram_raddr  = tgt_reg;
                state_next = S_FETCH_DATA;
            end

            S_FETCH_DATA:
            begin
                res_next.value_out = ram_rdata;
                if (kind_reg == KIND_GET)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = CW'(tgt_reg);
                    state_next = S_DEL_RD;
                end
            end

            // Close the gap: pull each later cell down by one.
            S_DEL_RD:
            begin
                if (idx_p1 < count_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_p1[AW-1:0];
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_EMIT;
                end
            end

            S_DEL_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_p1;
                state_next = S_DEL_RD;
            end

            S_PRINT_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_PRINT_EMIT;
            end

            S_PRINT_EMIT:
            begin
                res_valid = 1'b1;
                res       = '{status: STATUS_OK, value_out: ram_rdata, last: print_last};
                if (res_ready)
                begin
                    if (print_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_p1;
                        state_next = S_PRINT_RD;
                    end
                end
            end

            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
            val_reg   <= val_next;
            tgt_reg   <= tgt_next;
            idx_reg   <= idx_next;
            res_reg   <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in work");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + CW'(1) ||
             count_reg == $past(count_reg) - CW'(1)))
        else $error("element count moved by more than one");

    a_no_write_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && res_valid))
        else $error("store written while a result is offered");
`endif

endmodule

@@ hw/rtl/positional_char_list_unit.sv @@
// ----------------------------------------------------------------------------
// positional_char_list_unit: bounded ordered list of byte characters
// Insert, delete, get and print-all on a 1-based positional list.
// ----------------------------------------------------------------------------
// The unit holds up to CAPACITY bytes in order in a RAM and serves one request
// transaction at a time. Insert puts a byte at a 1-based position (valid from 1
// to count+1), delete removes and returns the byte at a position, get returns
// it, and print streams every byte in order with last set on the final one.
// A bad position gives the invalid-position status, insert into a full list
// the list-full status, and print of an empty list a single list-empty
// result; value_out is 0 on any result that is not a successful delete, get
// or print. Every operation walks the store through the one RAM read and one
// RAM write port under a small sequencer, so its cost follows the number of
// cells touched: insert moves every cell from the insert position up, delete
// every cell after the deleted one down, and print reads every cell. req_ready
// is low while a request is in work. A result register on the response side
// lets the sequencer finish or start the next request while the last result
// waits for rsp_ready. No clearing pass follows reset: cells are read only
// after they have been written.
// ----------------------------------------------------------------------------
module positional_char_list_unit #(
    parameter int CAPACITY = pcl_pkg::PCL_CAPACITY
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  pcl_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pcl_pkg::rsp_t rsp
);

    import pcl_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic              res_valid;
    logic              res_ready;
    rsp_t              res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    // Element store: cells 0 .. count-1 hold the list in order.
    pcl_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pcl_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Output register: take a new result whenever the slot is empty or its
    // transaction completes in this cycle; otherwise hold.
    assign res_ready = !out_valid_reg || rsp_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

@@ verif/positional_char_list_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_char_list_unit_test: self-checking bench for the character list
// Drives insert, delete, get and print transactions with bursty request
// traffic and a stalling response side, and checks every response against a
// queue-based copy of the list kept in a small scoreboard class.
// ----------------------------------------------------------------------------

module positional_char_list_unit_test;

    import pcl_pkg::*;

    // Mirror of the list contents; turns each accepted request into the
    // responses it must produce and checks them in order.
    class char_list_scoreboard;
        logic [CHAR_W-1:0] list_chars[$];
        rsp_t              expected_rsps[$];
        int                capacity;
        int                n_errors;

        function new(int cap);
            capacity = cap;
            n_errors = 0;
        endfunction

        function int list_size();
            return list_chars.size();
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction

        function void push_rsp(status_t st, logic [CHAR_W-1:0] v, logic fin);
            rsp_t e;
            e.status    = st;
            e.value_out = v;
            e.last      = fin;
            expected_rsps.push_back(e);
        endfunction

        function void note_request(req_t r);
            int p;
            int n;
            p = r.position;
            n = list_chars.size();
            case (r.kind) inside
                KIND_INSERT:
                begin
                    if (p == 0 || p > n + 1)
                        push_rsp(STATUS_BADPOS, '0, 1'b1);
                    else if (n >= capacity)
                        push_rsp(STATUS_FULL, '0, 1'b1);
                    else
                    begin
                        list_chars.insert(p - 1, r.value);
                        push_rsp(STATUS_OK, '0, 1'b1);
                    end
                end
                KIND_DELETE, KIND_GET:
                begin
                    if (p == 0 || p > n)
                        push_rsp(STATUS_BADPOS, '0, 1'b1);
                    else
                    begin
                        push_rsp(STATUS_OK, list_chars[p - 1], 1'b1);
                        if (r.kind == KIND_DELETE)
                            list_chars.delete(p - 1);
                    end
                end
                default:
                begin
                    if (n == 0)
                        push_rsp(STATUS_EMPTY, '0, 1'b1);
                    else
                        for (int i = 0; i < n; i++)
                            push_rsp(STATUS_OK, list_chars[i], i == n - 1);
                end
            endcase
        endfunction

        function void check_response(rsp_t r);
            rsp_t e;
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response: status %0d value_out %0h last %0d",
                       r.status, r.value_out, r.last);
                n_errors++;
                return;
            end
            e = expected_rsps.pop_front();
            if (r.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, r.status);
                n_errors++;
            end
            if (r.value_out !== e.value_out)
            begin
                $error("value_out: expected %0h, got %0h", e.value_out, r.value_out);
                n_errors++;
            end
            if (r.last !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, r.last);
                n_errors++;
            end
        endfunction
    endclass

    localparam int CAPACITY     = PCL_CAPACITY;
    localparam int RANDOM_OPS   = 440;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 150;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    char_list_scoreboard list_sb;

    int cycle_count;
    int burst_left;     // request transactions left in the current burst
    int stall_mode;     // response-side back-pressure style
    int mode_left;      // cycles until the style changes
    int stall_left;     // remaining cycles of a long stall

    positional_char_list_unit #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    // Abort a hung run: count every cycle and give up past the limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("positional_char_list_unit_test: errors");
            $finish;
        end
    end

    // Response monitor: sample at the rising edge, check every transaction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            list_sb.check_response(rsp);
    end

    // Response back-pressure. Switch the style after a random stretch so that
    // stalls hit every stage of the unit's work, including stretches where
    // ready simply stays high.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready = 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: rsp_ready = 1'b1;
                1: rsp_ready = $urandom_range(0, 1);
                2: rsp_ready = (cycle_count % 3) != 0;
                default:
                begin
                    // Mostly ready, with an occasional long stall.
                    if ($urandom_range(0, 7) == 0)
                    begin
                        stall_left = $urandom_range(2, 10);
                        rsp_ready  = 1'b0;
                    end
                    else
                        rsp_ready = 1'b1;
                end
            endcase
        end
    end

    // Present one request transaction and hold it until accepted. Called and
    // returns at a falling edge. Between bursts drop valid for a random gap.
    task automatic send_op(input kind_t k, input int pos, input logic [CHAR_W-1:0] v);
        req_t item;
        item.kind     = k;
        item.position = pos[POS_W-1:0];
        item.value    = v;
        if (burst_left == 0)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            // Now and then allow a long burst with no gaps at all.
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_valid = 1'b1;
        req       = item;
        do
            @(posedge clk);
        while (!req_ready);
        list_sb.note_request(item);
        @(negedge clk);
    endtask

    // Directed opening: empty-list corners, edge positions, extreme bytes,
    // insertion at front, middle and tail, and removal from each place.
    task automatic run_directed();
        send_op(KIND_PRINT,  0, 8'h00);   // print of an empty list
        send_op(KIND_GET,    1, 8'h00);   // get on an empty list
        send_op(KIND_DELETE, 0, 8'h00);   // position zero on delete
        send_op(KIND_INSERT, 0, 8'h11);   // position zero on insert
        send_op(KIND_INSERT, 2, 8'h22);   // insert past count + 1
        send_op(KIND_INSERT, 1, 8'h00);
        send_op(KIND_INSERT, 1, 8'hFF);   // new head
        send_op(KIND_INSERT, 3, 8'h5A);   // append at count + 1
        send_op(KIND_INSERT, 2, 8'hA5);   // middle
        send_op(KIND_INSERT, 6, 8'h33);   // one past the valid range
        send_op(KIND_GET,    0, 8'h00);
        send_op(KIND_GET,    4, 8'h00);   // tail
        send_op(KIND_GET,    1, 8'h00);   // head
        send_op(KIND_GET,    5, 8'h00);   // count + 1 is not readable
        send_op(KIND_GET,   63, 8'hFF);   // all position bits set
        send_op(KIND_PRINT,  0, 8'h00);
        send_op(KIND_DELETE, 2, 8'h00);   // middle
        send_op(KIND_DELETE, 3, 8'h00);   // tail
        send_op(KIND_DELETE, 1, 8'h00);   // head
        send_op(KIND_DELETE, 2, 8'h00);   // past the end
        send_op(KIND_DELETE, 1, 8'h00);   // empties the list
        send_op(KIND_PRINT,  0, 8'h00);
        send_op(KIND_INSERT, 63, 8'h7E);
    endtask

    // Random part. Steer the fill level toward a target that changes per
    // segment, so the list runs empty, full and in between; the first
    // segment aims at a full list to exercise the full case. A share of
    // the traffic is unconstrained noise and near-miss positions.
    task automatic run_random();
        int    target;
        int    seg_left;
        int    n;
        int    roll;
        int    pos;
        kind_t k;
        target   = CAPACITY;
        seg_left = 90;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (seg_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: target = 0;
                    1: target = CAPACITY;
                    2: target = $urandom_range(1, 3);
                    default: target = $urandom_range(4, CAPACITY - 1);
                endcase
                seg_left = $urandom_range(30, 70);
            end
            seg_left--;
            n    = list_sb.list_size();
            roll = $urandom_range(0, 99);
            if (roll < 7)
            begin
                send_op(KIND_PRINT, $urandom_range(0, 63),
                        CHAR_W'($urandom_range(0, 255)));
            end
            else if (roll < 13)
            begin
                k = kind_t'($urandom_range(0, 3));
                send_op(k, $urandom_range(0, 63), CHAR_W'($urandom_range(0, 255)));
            end
            else
            begin
                if (n < target)
                    k = ($urandom_range(0, 9) < 8) ? KIND_INSERT : KIND_GET;
                else if (n > target)
                    k = ($urandom_range(0, 9) < 8) ? KIND_DELETE : KIND_GET;
                else
                    k = kind_t'($urandom_range(0, 2));
                if (k == KIND_INSERT)
                    pos = $urandom_range(1, n + 1);
                else
                    pos = (n == 0) ? 1 : $urandom_range(1, n);
                // Occasionally step just past the valid range.
                if ($urandom_range(0, 19) == 0)
                    pos = (k == KIND_INSERT) ? n + 2 : n + 1;
                send_op(k, pos, CHAR_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b0;
        cycle_count = 0;
        burst_left  = 0;
        stall_mode  = 0;
        mode_left   = 0;
        stall_left  = 0;
        list_sb     = new(CAPACITY);

        // Hold reset low, then release it at a falling edge.
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random();
        req_valid = 1'b0;

        // Drain: wait for every expected response, then watch a little
        // longer for anything extra.
        while (list_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (list_sb.n_errors == 0)
            $display("positional_char_list_unit_test: clean");
        else
            $display("positional_char_list_unit_test: errors");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pcl_pkg.sv
hw/rtl/pcl_ram.sv
hw/rtl/pcl_seq.sv
hw/rtl/positional_char_list_unit.sv
verif/positional_char_list_unit_test.sv
